// ----- sv/dda_line_rasterizer_defines.svh -----
// Assertion macros used by the checker file.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// cons must hold in the clock after ante
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cons must hold in the same clock as ante
`define DDA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/dda_pkg.sv -----
package dda_pkg;

    localparam int COORD_BITS = 11;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic                  last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_RUN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic step_load;
        logic adv;
    } t_dp_cmd;

    typedef struct packed {
        logic steps_zero;
        logic left_one;
    } t_dp_stat;

endpackage

// ----- sv/dda_div.sv -----
module dda_div import dda_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  logic [COORD_BITS+FRAC_BITS-1:0]   i_dividend,
    input  logic [COORD_BITS-1:0]             i_divisor,
    output logic [COORD_BITS+FRAC_BITS-1:0]   o_quot
);

    localparam int DW = COORD_BITS + FRAC_BITS;

    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_div;
    logic [DW-1:0]         r_quo;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    // restoring division, one quotient bit per step
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (i_step) begin
            r_rem <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_quot = r_quo;

endmodule

// ----- sv/dda_datapath.sv -----
module dda_datapath import dda_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  t_in_item  i_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_data
);

    localparam int DW = COORD_BITS + FRAC_BITS;
    localparam int PW = COORD_BITS + FRAC_BITS + 2;
    localparam int SW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam logic [PW:0] HALF = {{(PW-FRAC_BITS+1){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic [PW-1:0]         r_pos_x;
    logic [PW-1:0]         r_pos_y;
    logic [SW-1:0]         r_step_x;
    logic [SW-1:0]         r_step_y;
    logic [COORD_BITS-1:0] r_left;
    logic                  r_neg_x;
    logic                  r_neg_y;
    t_out_item             r_out;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_neg;
    logic [COORD_BITS:0]   dy_neg;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] steps;
    logic [DW-1:0]         dividend_x;
    logic [DW-1:0]         dividend_y;
    logic [DW-1:0]         quot_x;
    logic [DW-1:0]         quot_y;
    logic [SW-1:0]         mag_x;
    logic [SW-1:0]         mag_y;
    logic [SW-1:0]         inc_x;
    logic [SW-1:0]         inc_y;
    logic [SW-1:0]         add_x;
    logic [SW-1:0]         add_y;
    logic [PW-1:0]         sum_x;
    logic [PW-1:0]         sum_y;

    // round half away from zero, clamp to the coordinate range
    function automatic logic [COORD_BITS-1:0] f_round(input logic [PW-1:0] p);
        logic [PW:0]             sum;
        logic [PW-FRAC_BITS:0]   whole;
        logic [COORD_BITS-1:0]   res;
        sum   = {1'b0, p} + HALF;
        whole = sum[PW:FRAC_BITS];
        if (p[PW-1]) begin
            res = '0;
        end else if (|whole[PW-FRAC_BITS:COORD_BITS]) begin
            res = '1;
        end else begin
            res = whole[COORD_BITS-1:0];
        end
        return res;
    endfunction

    always_comb begin
        dx     = {1'b0, i_data.end_x} - {1'b0, i_data.start_x};
        dy     = {1'b0, i_data.end_y} - {1'b0, i_data.start_y};
        dx_neg = -dx;
        dy_neg = -dy;
        ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        steps  = (ax > ay) ? ax : ay;
        dividend_x = {ax, {FRAC_BITS{1'b0}}} + {{(DW-COORD_BITS+1){1'b0}}, steps[COORD_BITS-1:1]};
        dividend_y = {ay, {FRAC_BITS{1'b0}}} + {{(DW-COORD_BITS+1){1'b0}}, steps[COORD_BITS-1:1]};

        mag_x = {1'b0, quot_x[QW-1:0]};
        mag_y = {1'b0, quot_y[QW-1:0]};
        inc_x = r_neg_x ? (~mag_x + 1'b1) : mag_x;
        inc_y = r_neg_y ? (~mag_y + 1'b1) : mag_y;
        add_x = i_cmd.step_load ? inc_x : r_step_x;
        add_y = i_cmd.step_load ? inc_y : r_step_y;
        sum_x = r_pos_x + {{(PW-SW){add_x[SW-1]}}, add_x};
        sum_y = r_pos_y + {{(PW-SW){add_y[SW-1]}}, add_y};

        o_stat.steps_zero = (steps == '0);
        o_stat.left_one   = (r_left == COORD_BITS'(1));
    end

    dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk      (i_clk),
        .i_load     (i_cmd.start),
        .i_step     (i_cmd.div_step),
        .i_dividend (dividend_x),
        .i_divisor  (steps),
        .o_quot     (quot_x)
    );

    dda_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk      (i_clk),
        .i_load     (i_cmd.start),
        .i_step     (i_cmd.div_step),
        .i_dividend (dividend_y),
        .i_divisor  (steps),
        .o_quot     (quot_y)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos_x       <= {2'b00, i_data.start_x, {FRAC_BITS{1'b0}}};
            r_pos_y       <= {2'b00, i_data.start_y, {FRAC_BITS{1'b0}}};
            r_left        <= steps;
            r_neg_x       <= dx[COORD_BITS];
            r_neg_y       <= dy[COORD_BITS];
            r_out.pixel_x <= i_data.start_x;
            r_out.pixel_y <= i_data.start_y;
            r_out.last    <= o_stat.steps_zero;
        end else if (i_cmd.step_load) begin
            r_step_x <= inc_x;
            r_step_y <= inc_y;
            r_pos_x  <= sum_x;
            r_pos_y  <= sum_y;
        end else if (i_cmd.adv) begin
            r_out.pixel_x <= f_round(r_pos_x);
            r_out.pixel_y <= f_round(r_pos_y);
            r_out.last    <= o_stat.left_one;
            r_pos_x       <= sum_x;
            r_pos_y       <= sum_y;
            r_left        <= r_left - 1'b1;
        end
    end

    assign o_data = r_out;

endmodule

// ----- sv/dda_ctrl.sv -----
module dda_ctrl import dda_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_kind,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam int DIV_STEPS = COORD_BITS + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             acc;

    always_comb begin
        o_ready = ((r_state == ST_IDLE) || (r_state == ST_RUN)) && (!r_out_valid || i_ready);
        acc     = i_valid && o_ready;

        o_cmd.start     = acc && (i_kind == KIND_START);
        o_cmd.adv       = acc && (i_kind == KIND_ADVANCE) && (r_state == ST_RUN);
        o_cmd.div_step  = (r_state == ST_DIV);
        o_cmd.step_load = (r_state == ST_ADD);

        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE, ST_RUN: begin
                if (o_cmd.start) begin
                    n_state = i_stat.steps_zero ? ST_IDLE : ST_DIV;
                    n_cnt   = CNT_W'(DIV_STEPS - 1);
                end else if (o_cmd.adv && i_stat.left_one) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.start || o_cmd.adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- sv/dda_line_rasterizer.sv -----
// DDA line generator. A start item (kind 0) loads two endpoints and its first
// pixel appears in the output register on the next cycle; the block then
// computes the x and y increments with two bit-serial dividers and holds off
// input while they run and the first increment is added, unless the
// endpoints are equal. After that each advance item (kind 1) is taken
// and yields the next pixel, one per cycle while the output side keeps
// taking them; the final pixel of a line carries last.
// An advance with no line in progress is accepted and produces nothing.
module dda_line_rasterizer import dda_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_data.kind),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    dda_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk  (i_clk),
        .i_data (i_data),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_data (o_data)
    );

endmodule

// ----- sv/dda_chk.sv -----
`include "dda_line_rasterizer_defines.svh"

module dda_chk import dda_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    logic start_acc;
    logic same_pts;

    assign start_acc = i_valid && o_ready && (i_data.kind == KIND_START);
    assign same_pts  = (i_data.start_x == i_data.end_x) && (i_data.start_y == i_data.end_y);

    `DDA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data), "stalled item changed")
    `DDA_ASSERT_SAME(a_room, o_ready && o_valid, i_ready, "input taken with output slot full")
    `DDA_ASSERT_NEXT(a_first_px, start_acc, o_valid && (o_data.pixel_x == $past(i_data.start_x)) && (o_data.pixel_y == $past(i_data.start_y)) && (o_data.last == $past(same_pts)), "first pixel wrong")
    `DDA_ASSERT_NEXT(a_div_wait, start_acc && !same_pts, !o_ready, "input taken during divide")

endmodule

bind dda_line_rasterizer dda_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import dda_pkg::*;

    localparam int FRAC      = 16;
    localparam int POS_W     = COORD_BITS + FRAC + 1;
    localparam int STEP_W    = FRAC + 2;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    dda_line_rasterizer #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // line tracker state
    logic signed [POS_W-1:0]  trk_pos_x = '0;
    logic signed [POS_W-1:0]  trk_pos_y = '0;
    logic signed [STEP_W-1:0] trk_step_x = '0;
    logic signed [STEP_W-1:0] trk_step_y = '0;
    int                       trk_left = 0;
    bit                       trk_busy = 1'b0;

    t_out_item exp_pixels[$];
    t_out_item want_px;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_errors = 0;
    int n_accepted = 0;
    int n_idle_adv = 0;
    int n_lines = 0;
    int n_cut = 0;
    int n_checked = 0;
    int n_last = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic logic signed [STEP_W-1:0] fx_increment(int d, int steps);
        longint mag;
        longint q;
        mag = iabs(d);
        q = ((mag << FRAC) + steps / 2) / steps;
        return (d < 0) ? STEP_W'(-q) : STEP_W'(q);
    endfunction

    function automatic logic [COORD_BITS-1:0] round_pos(logic signed [POS_W-1:0] p);
        longint r;
        if (p < 0) return '0;
        r = (longint'(p) + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (r > COORD_MAX) r = COORD_MAX;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic void push_pixel(bit is_last);
        t_out_item px;
        px.pixel_x = round_pos(trk_pos_x);
        px.pixel_y = round_pos(trk_pos_y);
        px.last    = is_last;
        exp_pixels.push_back(px);
    endfunction

    function automatic void trace_line(t_in_item itm);
        int dx;
        int dy;
        int steps;
        if (itm.kind == KIND_START) begin
            dx = int'(itm.end_x) - int'(itm.start_x);
            dy = int'(itm.end_y) - int'(itm.start_y);
            steps = (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
            n_lines++;
            if (trk_busy) n_cut++;
            trk_pos_x = {1'b0, itm.start_x, {FRAC{1'b0}}};
            trk_pos_y = {1'b0, itm.start_y, {FRAC{1'b0}}};
            if (steps == 0) begin
                trk_step_x = '0;
                trk_step_y = '0;
                trk_left   = 0;
                trk_busy   = 1'b0;
                push_pixel(1'b1);
            end else begin
                trk_step_x = fx_increment(dx, steps);
                trk_step_y = fx_increment(dy, steps);
                trk_left   = steps;
                trk_busy   = 1'b1;
                push_pixel(1'b0);
                trk_pos_x += trk_step_x;
                trk_pos_y += trk_step_y;
            end
        end else if (!trk_busy) begin
            n_idle_adv++;
        end else begin
            trk_left--;
            if (trk_left == 0) begin
                trk_busy = 1'b0;
                push_pixel(1'b1);
            end else begin
                push_pixel(1'b0);
                trk_pos_x += trk_step_x;
                trk_pos_y += trk_step_y;
            end
        end
    endfunction

    function automatic t_in_item rand_advance();
        t_in_item itm;
        itm.kind    = KIND_ADVANCE;
        itm.start_x = COORD_BITS'($urandom_range(COORD_MAX));
        itm.start_y = COORD_BITS'($urandom_range(COORD_MAX));
        itm.end_x   = COORD_BITS'($urandom_range(COORD_MAX));
        itm.end_y   = COORD_BITS'($urandom_range(COORD_MAX));
        return itm;
    endfunction

    // called at a rising edge; returns at the edge that took the item
    task automatic send_item(t_in_item itm);
        if (src_idle_pct != 0) begin
            while ($urandom_range(99) < src_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= itm;
        do @(posedge i_clk); while (!o_ready);
        n_accepted++;
        trace_line(itm);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (exp_pixels.size() != 0);
    endtask

    task automatic run_line(int x0, int y0, int x1, int y1, int n_adv);
        t_in_item itm;
        itm = rand_advance();
        itm.kind    = KIND_START;
        itm.start_x = COORD_BITS'(x0);
        itm.start_y = COORD_BITS'(y0);
        itm.end_x   = COORD_BITS'(x1);
        itm.end_y   = COORD_BITS'(y1);
        send_item(itm);
        repeat (n_adv) send_item(rand_advance());
    endtask

    task automatic random_lines(int count);
        int goal;
        int pick;
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int steps;
        int n_adv;
        goal = n_accepted - n_idle_adv + count;
        while (n_accepted - n_idle_adv < goal) begin
            pick = $urandom_range(99);
            span = ($urandom_range(9) == 0) ? 90 : 12;
            x0 = $urandom_range(COORD_MAX);
            y0 = $urandom_range(COORD_MAX);
            if (pick >= 92) begin
                if ($urandom_range(1)) x0 = $urandom_range(1) ? COORD_MAX : 0;
                else y0 = $urandom_range(1) ? COORD_MAX : 0;
            end
            x1 = clamp_coord(x0 + $urandom_range(2 * span) - span);
            y1 = clamp_coord(y0 + $urandom_range(2 * span) - span);
            if (pick >= 75 && pick < 85) begin
                x1 = $urandom_range(COORD_MAX);
                y1 = $urandom_range(COORD_MAX);
            end
            steps = (iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0);
            if ($urandom_range(39) == 0) drain_results();
            if (pick >= 85 && pick < 92) begin
                // stray advances, idle or continuing a cut-short line
                repeat ($urandom_range(1, 3)) send_item(rand_advance());
            end else begin
                if (pick >= 75 && pick < 85)
                    n_adv = $urandom_range(0, (steps > 10) ? 10 : steps);
                else
                    n_adv = steps + (($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
                run_line(x0, y0, x1, y1, n_adv);
            end
        end
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_line(0, 0, 0, 0, 0);
        run_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        run_line(0, 5, 4, 5, 4);
        // half-step y lands on .5 and must round away from zero
        run_line(10, COORD_MAX, 12, COORD_MAX - 1, 2);
        run_line(3, 1, 0, 8, 7);
        run_line(0, 0, COORD_MAX, COORD_MAX, 2);
        run_line(COORD_MAX, 0, 0, COORD_MAX, 1);
    endtask

    task automatic test_full_rate();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        random_lines(380);
    endtask

    task automatic test_sender_gaps();
        src_idle_pct = 63;
        snk_idle_pct = 0;
        random_lines(380);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct = 0;
        snk_idle_pct = 63;
        random_lines(380);
    endtask

    task automatic test_mixed_idle();
        src_idle_pct = 7;
        snk_idle_pct = 7;
        random_lines(380);
    endtask

    task automatic test_drain_pause();
        int x0;
        int y0;
        int x1;
        int y1;
        int steps;
        src_idle_pct = 0;
        snk_idle_pct = 63;
        repeat (3) begin
            x0 = $urandom_range(COORD_MAX);
            y0 = $urandom_range(COORD_MAX);
            x1 = clamp_coord(x0 + $urandom_range(10) - 5);
            y1 = clamp_coord(y0 + $urandom_range(10) - 5);
            steps = (iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0);
            run_line(x0, y0, x1, y1, 0);
            drain_results();
            repeat (steps) begin
                send_item(rand_advance());
                if ($urandom_range(2) == 0) drain_results();
            end
        end
        drain_results();
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_pixels.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                         $time, o_data.pixel_x, o_data.pixel_y, o_data.last);
            end else begin
                want_px = exp_pixels.pop_front();
                n_checked++;
                if (want_px.last) n_last++;
                if (o_data !== want_px) begin
                    n_errors++;
                    $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                             $time, want_px.pixel_x, want_px.pixel_y, want_px.last,
                             o_data.pixel_x, o_data.pixel_y, o_data.last);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_rate();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        test_drain_pause();
        i_valid <= 1'b0;
        snk_idle_pct = 0;
        while (exp_pixels.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Drew %0d lines (%0d cut short by a new start) from %0d items,",
                 n_lines, n_cut, n_accepted);
        $display("checked %0d pixels (%0d line ends), %0d advances with no line active.",
                 n_checked, n_last, n_idle_adv);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
